@@ src/assert_macros.svh @@
// assertion macros for the port-level checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is active
`define QS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is active
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition that must hold on the cycle after a reset cycle
`define QS_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/qs_pkg.sv @@
// shared types, constants and the cordic arctangent table for the slerp unit
// no dependencies
`timescale 1ns / 1ps

package qs_pkg;

    typedef logic signed [15:0] t_q15;

    localparam int unsigned CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;
    localparam logic [16:0] T_ONE = 17'd65536;
    localparam logic [30:0] THR_RESET = 31'd1074;

    // truncated arctangents for the first ten iterations, q2.30 radians
    localparam logic [31:0] ATAN_HEAD [10] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
    };

    // side data that travels with each word down the pipeline
    typedef struct packed {
        logic [3:0][15:0] a;    // first quaternion
        logic [3:0][16:0] b;    // second quaternion, sign folded in
        logic [16:0]      t;    // clamped fraction
        logic             lin;  // linear weights
        logic [29:0]      c;    // |dot|, valid on the slerp path
        logic [30:0]      s;    // sqrt(1 - c*c)
    } t_side;

    // arctangent of 2^-i in q2.30
    function automatic logic [31:0] atan_entry(input int unsigned i);
        logic [31:0] r;
        logic [3:0]  idx;
        idx = 4'(i);
        if (i < 10) begin
            r = ATAN_HEAD[idx];
        end else begin
            r = 32'(64'd1 << (30 - i));
        end
        return r;
    endfunction

endpackage

@@ src/qs_if.sv @@
// valid/ready channels for the slerp unit: quaternion pair in, quaternion out
// depends on qs_pkg
`timescale 1ns / 1ps

interface qs_pair_if;
    logic           valid;
    logic           ready;
    qs_pkg::t_q15   from_x;
    qs_pkg::t_q15   from_y;
    qs_pkg::t_q15   from_z;
    qs_pkg::t_q15   from_w;
    qs_pkg::t_q15   to_x;
    qs_pkg::t_q15   to_y;
    qs_pkg::t_q15   to_z;
    qs_pkg::t_q15   to_w;
    logic [16:0]    fraction;

    modport source (
        output valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction,
        output ready
    );
endinterface

interface qs_result_if;
    logic           valid;
    logic           ready;
    qs_pkg::t_q15   out_x;
    qs_pkg::t_q15   out_y;
    qs_pkg::t_q15   out_z;
    qs_pkg::t_q15   out_w;

    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

@@ src/quaternion_slerp.sv @@
// pipelined fixed-point quaternion slerp: dot, sqrt, cordic angle, cordic sines, divide
// depends on qs_pkg and qs_if
`timescale 1ns / 1ps

// channel    dir  payload                                   handshake
// i_pair     in   from_x..w, to_x..w q1.15, fraction q1.16  valid/ready
// o_result   out  out_x..w q1.15 saturated                  valid/ready
// i_cfg      in   near_threshold q1.30, 31 bits             write enable only
//
// one pair per cycle while no result word is held; the depth is set by the 31 square root stages,
// two 30-stage cordic chains and the 46-stage restoring divider
// the whole pipeline holds as one while a finished word waits on o_result
// synchronous reset clears the valid bits and sets near_threshold to 1074

module quaternion_slerp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    qs_pair_if.sink            i_pair,
    qs_result_if.source        o_result
);

    localparam int unsigned ST_RAD     = 3;
    localparam int unsigned SQ_N       = 31;
    localparam int unsigned ST_SQ_END  = ST_RAD + SQ_N;
    localparam int unsigned ST_S       = ST_SQ_END + 1;
    localparam int unsigned VEC_N      = qs_pkg::CORDIC_STEPS;
    localparam int unsigned ST_VEC_END = ST_SQ_END + VEC_N;
    localparam int unsigned ST_MUL     = ST_VEC_END + 1;
    localparam int unsigned ST_ANG     = ST_MUL + 1;
    localparam int unsigned ST_ROT_END = ST_ANG + VEC_N;
    localparam int unsigned DIV_N      = 46;
    localparam int unsigned ST_DIV_END = ST_ROT_END + DIV_N;
    localparam int unsigned LAT        = ST_DIV_END + 2;

    logic                 adv;
    logic [30:0]          r_thr;
    logic                 r_vld [1:LAT];
    qs_pkg::t_side        r_side [1:ST_DIV_END];
    qs_pkg::t_side        n_side1;
    qs_pkg::t_side        n_side2;
    qs_pkg::t_side        n_side_s;

    // pipeline advance: move whenever the output slot is free or taken
    assign adv            = !r_vld[LAT] || o_result.ready;
    assign i_pair.ready   = adv;
    assign o_result.valid = r_vld[LAT];

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qs_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[1] <= i_pair.valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    // stage 1: clamp fraction, component products
    logic signed [15:0] in_a [4];
    logic signed [15:0] in_b [4];
    logic [16:0]        t_clamp;
    logic signed [31:0] r_p [4];

    assign in_a[0] = i_pair.from_x;
    assign in_a[1] = i_pair.from_y;
    assign in_a[2] = i_pair.from_z;
    assign in_a[3] = i_pair.from_w;
    assign in_b[0] = i_pair.to_x;
    assign in_b[1] = i_pair.to_y;
    assign in_b[2] = i_pair.to_z;
    assign in_b[3] = i_pair.to_w;
    assign t_clamp = (i_pair.fraction > qs_pkg::T_ONE) ? qs_pkg::T_ONE : i_pair.fraction;

    always_comb begin
        n_side1 = '0;
        for (int k = 0; k < 4; k++) begin
            n_side1.a[k] = in_a[k];
            n_side1.b[k] = 17'(in_b[k]);
        end
        n_side1.t = t_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= 32'(in_a[k]) * 32'(in_b[k]);
            end
            r_side[1] <= n_side1;
        end
    end

    // stage 2: dot product, fold sign, choose path
    logic signed [33:0] dot;
    logic signed [33:0] dot_abs;
    logic signed [34:0] one_minus;
    logic               slerp;

    assign dot       = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]);
    assign dot_abs   = dot[33] ? -dot : dot;
    assign one_minus = 35'sd1073741824 - 35'(dot_abs);
    assign slerp     = one_minus > $signed({4'b0000, r_thr});

    always_comb begin
        n_side2     = r_side[1];
        n_side2.c   = dot_abs[29:0];
        n_side2.lin = !slerp;
        for (int k = 0; k < 4; k++) begin
            if (dot[33]) begin
                n_side2.b[k] = 17'(-$signed(r_side[1].b[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[2] <= n_side2;
        end
    end

    // stage 3: radicand 2^60 - c*c
    logic [60:0] r_sq_n [0:SQ_N];
    logic [60:0] r_sq_r [0:SQ_N];
    logic [59:0] c_sq;

    assign c_sq = 60'(r_side[2].c) * 60'(r_side[2].c);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_n[0] <= (61'd1 << 60) - 61'(c_sq);
            r_sq_r[0] <= '0;
        end
    end

    // side data with the finished root merged in
    always_comb begin
        n_side_s   = r_side[ST_SQ_END];
        n_side_s.s = r_sq_r[SQ_N][30:0];
    end

    // side data shift, sqrt result joins after the root stages
    for (genvar k = 3; k <= ST_DIV_END; k++) begin : g_side
        if (k == ST_S) begin : g_join
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_side[k] <= n_side_s;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_side[k] <= r_side[k - 1];
                end
            end
        end
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        localparam int unsigned BPOS = 2 * (SQ_N - 1 - g);
        logic [61:0] trial;
        logic [60:0] n_n;
        logic [60:0] n_r;

        always_comb begin
            trial = {1'b0, r_sq_r[g]} + (62'd1 << BPOS);
            if ({1'b0, r_sq_n[g]} >= trial) begin
                n_n = r_sq_n[g] - trial[60:0];
                n_r = (r_sq_r[g] >> 1) + (61'd1 << BPOS);
            end else begin
                n_n = r_sq_n[g];
                n_r = r_sq_r[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_n[g + 1] <= n_n;
                r_sq_r[g + 1] <= n_r;
            end
        end
    end

    // cordic vectoring: angle of (c, s)
    logic signed [32:0] r_vx [1:VEC_N];
    logic signed [32:0] r_vy [1:VEC_N];
    logic signed [32:0] r_vz [1:VEC_N];

    for (genvar g = 0; g < VEC_N; g++) begin : g_vec
        logic signed [32:0] x_in;
        logic signed [32:0] y_in;
        logic signed [32:0] z_in;
        logic signed [32:0] atan_v;
        logic signed [32:0] n_x;
        logic signed [32:0] n_y;
        logic signed [32:0] n_z;

        if (g == 0) begin : g_first
            assign x_in = $signed({3'b000, r_side[ST_SQ_END].c});
            assign y_in = $signed({2'b00, r_sq_r[SQ_N][30:0]});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[g];
            assign y_in = r_vy[g];
            assign z_in = r_vz[g];
        end

        assign atan_v = $signed({1'b0, qs_pkg::atan_entry(g)});

        always_comb begin
            if (!y_in[32]) begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + atan_v;
            end else begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - atan_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_vx[g + 1] <= n_x;
                r_vy[g + 1] <= n_y;
                r_vz[g + 1] <= n_z;
            end
        end
    end

    // omega * t
    logic [30:0] omega;
    logic [30:0] r_om;
    logic [47:0] r_mp;

    assign omega = r_vz[VEC_N][32] ? 31'd0 : r_vz[VEC_N][30:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_om <= omega;
            r_mp <= 48'(omega) * 48'(r_side[ST_VEC_END].t);
        end
    end

    // split angle: t*omega rounded, remainder for 1-t
    logic [30:0] ang1;
    logic [30:0] r_ang [2];

    assign ang1 = 31'((r_mp + 48'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang[0] <= r_om - ang1;
            r_ang[1] <= ang1;
        end
    end

    // cordic rotation, two lanes for the two sines
    logic signed [32:0] r_rx [2][1:VEC_N];
    logic signed [32:0] r_ry [2][1:VEC_N];
    logic signed [32:0] r_rz [2][1:VEC_N];

    for (genvar l = 0; l < 2; l++) begin : g_rlane
        for (genvar g = 0; g < VEC_N; g++) begin : g_rot
            logic signed [32:0] x_in;
            logic signed [32:0] y_in;
            logic signed [32:0] z_in;
            logic signed [32:0] atan_v;
            logic signed [32:0] n_x;
            logic signed [32:0] n_y;
            logic signed [32:0] n_z;

            if (g == 0) begin : g_first
                assign x_in = qs_pkg::CORDIC_GAIN;
                assign y_in = '0;
                assign z_in = $signed({2'b00, r_ang[l]});
            end else begin : g_next
                assign x_in = r_rx[l][g];
                assign y_in = r_ry[l][g];
                assign z_in = r_rz[l][g];
            end

            assign atan_v = $signed({1'b0, qs_pkg::atan_entry(g)});

            always_comb begin
                if (!z_in[32]) begin
                    n_x = x_in - (y_in >>> g);
                    n_y = y_in + (x_in >>> g);
                    n_z = z_in - atan_v;
                end else begin
                    n_x = x_in + (y_in >>> g);
                    n_y = y_in - (x_in >>> g);
                    n_z = z_in + atan_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rx[l][g + 1] <= n_x;
                    r_ry[l][g + 1] <= n_y;
                    r_rz[l][g + 1] <= n_z;
                end
            end
        end
    end

    // restoring divide (sine << 30) / s, one quotient bit per stage
    logic [31:0] r_dr [2][1:DIV_N];
    logic [30:0] r_dd [2][1:DIV_N];
    logic [45:0] r_dq [2][1:DIV_N];

    for (genvar l = 0; l < 2; l++) begin : g_dlane
        for (genvar g = 0; g < DIV_N; g++) begin : g_div
            localparam int unsigned QPOS = DIV_N - 1 - g;
            logic [31:0] rem_in;
            logic [30:0] dd_in;
            logic [45:0] q_in;
            logic [31:0] rem_sh;
            logic [31:0] divisor;
            logic        nbit;
            logic        qbit;
            logic [31:0] n_rem;

            if (g == 0) begin : g_first
                logic [30:0] sine;
                assign sine   = r_ry[l][VEC_N][32] ? 31'd0 : r_ry[l][VEC_N][30:0];
                assign rem_in = {17'd0, sine[30:16]};
                assign dd_in  = sine;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_dr[l][g];
                assign dd_in  = r_dd[l][g];
                assign q_in   = r_dq[l][g];
            end

            if (QPOS >= 30) begin : g_dbit
                assign nbit = dd_in[QPOS - 30];
            end else begin : g_zbit
                assign nbit = 1'b0;
            end

            assign divisor = {1'b0, r_side[ST_ROT_END + g].s};
            assign rem_sh  = {rem_in[30:0], nbit};
            assign qbit    = rem_sh >= divisor;
            assign n_rem   = qbit ? (rem_sh - divisor) : rem_sh;

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dr[l][g + 1] <= n_rem;
                    r_dd[l][g + 1] <= dd_in;
                    r_dq[l][g + 1] <= {q_in[44:0], qbit};
                end
            end
        end
    end

    // weight select and weighted products
    logic [45:0]        w0;
    logic [45:0]        w1;
    logic signed [63:0] r_pa [4];
    logic signed [63:0] r_pb [4];

    assign w0 = r_side[ST_DIV_END].lin
              ? {15'd0, qs_pkg::T_ONE - r_side[ST_DIV_END].t, 14'd0}
              : r_dq[0][DIV_N];
    assign w1 = r_side[ST_DIV_END].lin
              ? {15'd0, r_side[ST_DIV_END].t, 14'd0}
              : r_dq[1][DIV_N];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_pa[k] <= $signed({18'd0, w0}) * 64'($signed(r_side[ST_DIV_END].a[k]));
                r_pb[k] <= $signed({18'd0, w1}) * 64'($signed(r_side[ST_DIV_END].b[k]));
            end
        end
    end

    // round, shift and saturate into the output register
    logic signed [15:0] r_out [4];
    logic signed [15:0] n_out [4];

    always_comb begin
        logic signed [64:0] acc;
        logic signed [34:0] v;
        for (int k = 0; k < 4; k++) begin
            acc = 65'(r_pa[k]) + 65'(r_pb[k]) + 65'sd536870912;
            v   = acc[64:30];
            if (v > 35'sd32767) begin
                n_out[k] = 16'sh7FFF;
            end else if (v < -35'sd32768) begin
                n_out[k] = 16'sh8000;
            end else begin
                n_out[k] = v[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= n_out[k];
            end
        end
    end

    assign o_result.out_x = r_out[0];
    assign o_result.out_y = r_out[1];
    assign o_result.out_z = r_out[2];
    assign o_result.out_w = r_out[3];

endmodule

@@ src/qs_checker.sv @@
// port-level checks for the slerp unit, bound to the top level
// depends on assert_macros.svh and quaternion_slerp
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_word
);

    // a held result word stays offered
    `QS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a held result word keeps its payload
    `QS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_word))

    // input waits only while the output word is held
    `QS_ASSERT_IMPLY(a_in_open, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready)

    // a held output word stops intake
    `QS_ASSERT_IMPLY(a_in_block, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)

    // reset empties the pipeline
    `QS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !i_out_valid)

endmodule

bind quaternion_slerp qs_checker u_qs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_word  ({o_result.out_x, o_result.out_y, o_result.out_z, o_result.out_w})
);

@@ bench/qs_slerp_checker.sv @@
// checker for the slerp unit: watches the pair and result channels, predicts, compares
// depends on qs_pkg and qs_if
`timescale 1ns / 1ps

module qs_slerp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    qs_pair_if          pair,
    qs_result_if        res,
    output int          o_pending,
    output int          o_errors
);

    typedef struct {
        qs_pkg::t_q15 x;
        qs_pkg::t_q15 y;
        qs_pkg::t_q15 z;
        qs_pkg::t_q15 w;
    } t_quat;

    localparam longint ARCTAN_Q30 [10] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD
    };
    localparam longint ROT_GAIN = 64'h26DD3B6A;

    t_quat        expected_quats [$];
    logic [30:0]  thr_q30;

    function automatic longint arctan_step(input int i);
        longint r;
        if (i < 10) begin
            r = ARCTAN_Q30[i];
        end else begin
            r = longint'(1) << (30 - i);
        end
        return r;
    endfunction

    // integer square root, bit by bit
    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned pw;
        r  = 0;
        pw = 64'd1 << 62;
        while (pw > n) pw = pw >> 2;
        while (pw != 0) begin
            if (n >= r + pw) begin
                n = n - (r + pw);
                r = (r >> 1) + pw;
            end else begin
                r = r >> 1;
            end
            pw = pw >> 2;
        end
        return r;
    endfunction

    // vectoring: angle of (x, y) in q2.30
    function automatic longint vec_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    // rotation: sine of a q2.30 angle
    function automatic longint rot_sine(input longint z);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        return y;
    endfunction

    function automatic longint sine_weight(input longint sine, input longint unsigned s);
        longint unsigned num;
        if (sine < 0) sine = 0;
        if (s == 0) return 0;
        num = longint'(sine) << 30;
        return longint'(num / s);
    endfunction

    function automatic t_quat slerp_expect(input longint a [4], input longint b_in [4],
                                           input logic [16:0] frac, input logic [30:0] thr);
        longint b [4];
        longint c;
        longint w0;
        longint w1;
        longint omega;
        longint ang1;
        longint v;
        longint unsigned s;
        longint unsigned t;
        qs_pkg::t_q15 o [4];
        t_quat q;
        t = (frac > 17'd65536) ? 65536 : frac;
        c = 0;
        for (int k = 0; k < 4; k++) begin
            b[k] = b_in[k];
            c += a[k] * b[k];
        end
        // fold to the short arc
        if (c < 0) begin
            c = -c;
            for (int k = 0; k < 4; k++) b[k] = -b[k];
        end
        if ((longint'(1) << 30) - c > longint'(thr)) begin
            s = int_root((64'd1 << 60) - longint'(c * c));
            omega = vec_angle(c, longint'(s));
            if (omega < 0) omega = 0;
            ang1 = longint'((longint'(omega) * t + 32768) >> 16);
            w0 = sine_weight(rot_sine(omega - ang1), s);
            w1 = sine_weight(rot_sine(ang1), s);
        end else begin
            w0 = longint'(65536 - t) << 14;
            w1 = longint'(t) << 14;
        end
        for (int k = 0; k < 4; k++) begin
            v = (w0 * a[k] + w1 * b[k] + (longint'(1) << 29)) >>> 30;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            o[k] = qs_pkg::t_q15'(v);
        end
        q.x = o[0]; q.y = o[1]; q.z = o[2]; q.w = o[3];
        return q;
    endfunction

    initial o_errors = 0;
    initial o_pending = 0;

    // predict on each accepted pair, compare each accepted word
    always @(posedge i_clk) begin
        longint a [4];
        longint b [4];
        t_quat got;
        t_quat want;
        if (!i_rst_n) begin
            thr_q30 = qs_pkg::THR_RESET;
            expected_quats.delete();
        end else begin
            if (pair.valid && pair.ready) begin
                a = '{pair.from_x, pair.from_y, pair.from_z, pair.from_w};
                b = '{pair.to_x, pair.to_y, pair.to_z, pair.to_w};
                expected_quats.push_back(slerp_expect(a, b, pair.fraction, thr_q30));
            end
            if (res.valid && res.ready) begin
                got.x = res.out_x; got.y = res.out_y; got.z = res.out_z; got.w = res.out_w;
                if (expected_quats.size() == 0) begin
                    $error("result word with nothing expected");
                    o_errors++;
                end else begin
                    want = expected_quats.pop_front();
                    if (got.x !== want.x) begin
                        $error("out_x expected %0d actual %0d", want.x, got.x); o_errors++;
                    end
                    if (got.y !== want.y) begin
                        $error("out_y expected %0d actual %0d", want.y, got.y); o_errors++;
                    end
                    if (got.z !== want.z) begin
                        $error("out_z expected %0d actual %0d", want.z, got.z); o_errors++;
                    end
                    if (got.w !== want.w) begin
                        $error("out_w expected %0d actual %0d", want.w, got.w); o_errors++;
                    end
                end
            end
            if (i_cfg_we) thr_q30 = i_cfg_wdata;
        end
        o_pending <= expected_quats.size();
    end

endmodule

@@ bench/tb_quaternion_slerp.sv @@
// testbench top for the slerp unit: stimulus, idling, pressure and verdict
// depends on qs_pkg, qs_if, quaternion_slerp and qs_slerp_checker
`timescale 1ns / 1ps

module tb_quaternion_slerp;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          pending_words;
    int          mismatches;
    int          cycle_count = 0;

    qs_pair_if   pair_ch ();
    qs_result_if result_ch ();

    quaternion_slerp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pair      (pair_ch),
        .o_result    (result_ch)
    );

    qs_slerp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .pair        (pair_ch),
        .res         (result_ch),
        .o_pending   (pending_words),
        .o_errors    (mismatches)
    );

    always #1 i_clk = ~i_clk;

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quaternion_slerp test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-off when requested
    initial result_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            result_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one pair word, with random sender gaps
    task automatic send_pair(input logic signed [15:0] f [4], input logic signed [15:0] g [4],
                             input logic [16:0] frac);
        logic done;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pair_ch.valid    <= 1'b1;
        pair_ch.from_x   <= f[0]; pair_ch.from_y <= f[1];
        pair_ch.from_z   <= f[2]; pair_ch.from_w <= f[3];
        pair_ch.to_x     <= g[0]; pair_ch.to_y   <= g[1];
        pair_ch.to_z     <= g[2]; pair_ch.to_w   <= g[3];
        pair_ch.fraction <= frac;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = pair_ch.ready;
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        pair_ch.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [16:0] pick_fraction();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 17'd0;
        if (r == 1) return 17'd65536;
        if (r == 2) return 17'($urandom_range(131071, 65537));
        return 17'($urandom_range(65535));
    endfunction

    // random pair: mostly unit quaternions, some close together, some raw noise
    task automatic send_random_pair();
        logic signed [15:0] f [4];
        logic signed [15:0] g [4];
        real fr [4];
        real len;
        int kind;
        kind = $urandom_range(9);
        if (kind < 2) begin
            for (int k = 0; k < 4; k++) begin
                f[k] = 16'($urandom);
                g[k] = 16'($urandom);
            end
        end else begin
            len = 0.0;
            for (int k = 0; k < 4; k++) begin
                fr[k] = real'($urandom_range(2000)) - 1000.0;
                len += fr[k] * fr[k];
            end
            if (len == 0.0) begin
                fr[3] = 1.0; len = 1.0;
            end
            len = $sqrt(len);
            for (int k = 0; k < 4; k++) f[k] = 16'($rtoi(fr[k] / len * 32767.0));
            for (int k = 0; k < 4; k++) begin
                if (kind < 5) begin
                    // near pair, possibly the opposite sign
                    g[k] = f[k] + 16'($signed($urandom_range(8)) - 4);
                    if (kind == 4) g[k] = -g[k];
                end else begin
                    g[k] = 16'($urandom);
                end
            end
            if (kind >= 5) begin
                len = 0.0;
                for (int k = 0; k < 4; k++) len += real'(g[k]) * real'(g[k]);
                if (len > 0.0) begin
                    len = $sqrt(len);
                    for (int k = 0; k < 4; k++) g[k] = 16'($rtoi(real'(g[k]) / len * 32767.0));
                end
            end
        end
        send_pair(f, g, pick_fraction());
    endtask

    task automatic send_directed();
        logic signed [15:0] f [4];
        logic signed [15:0] g [4];
        // extremes of every field
        f = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        g = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_pair(f, g, 17'd0);
        g = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_pair(f, g, 17'd65536);
        send_pair(g, g, 17'h1FFFF);
        f = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_pair(f, f, 17'd32768);
        // identical unit quaternions: near path only at a threshold of 65535 or more
        f = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF};
        send_pair(f, f, 17'd16384);
        // orthogonal: full slerp while the threshold is below one
        g = '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000};
        send_pair(f, g, 17'd32768);
        send_pair(f, g, 17'd0);
        send_pair(f, g, 17'd65536);
        send_pair(f, g, 17'd100000);
        // negative dot, with a -32768 component to negate
        g = '{16'sh0000, 16'sh0000, 16'sh4000, 16'sh8000};
        send_pair(f, g, 17'd20000);
        g = '{16'sh0000, 16'sh2000, 16'sh0000, 16'shA000};
        send_pair(f, g, 17'd45000);
        // unnormalized, dot above one
        f = '{16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000};
        send_pair(f, f, 17'd30000);
        // 45 degrees apart
        g = '{16'sh5A82, 16'sh0000, 16'sh0000, 16'sh5A82};
        f = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF};
        send_pair(f, g, 17'd1);
        send_pair(f, g, 17'd65535);
        // alternating bit patterns
        f = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA};
        g = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555};
        send_pair(f, g, 17'h15555);
        send_pair(g, f, 17'h0AAAA);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_pair();
    endtask

    initial begin
        pair_ch.valid    = 1'b0;
        pair_ch.from_x   = '0; pair_ch.from_y = '0; pair_ch.from_z = '0; pair_ch.from_w = '0;
        pair_ch.to_x     = '0; pair_ch.to_y   = '0; pair_ch.to_z   = '0; pair_ch.to_w   = '0;
        pair_ch.fraction = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset threshold
        send_directed();
        run_phase(0, 0, 300);
        go_idle();

        // threshold zero, receiver holds off while words keep coming
        write_threshold(31'd0);
        send_directed();
        hold_cycles = 600;
        run_phase(0, 0, 250);
        run_phase(50, 0, 200);
        go_idle();

        // one: linear weights always
        write_threshold(31'h40000000);
        send_directed();
        run_phase(0, 50, 200);
        go_idle();

        // all ones
        write_threshold(31'h7FFFFFFF);
        run_phase(37, 37, 150);
        go_idle();

        // moderate threshold, catches the near pairs
        write_threshold(31'($urandom_range(2000000, 20000)));
        run_phase(37, 37, 350);
        run_phase(0, 0, 150);
        go_idle();

        write_threshold(31'($urandom_range(32'h40000000)));
        run_phase(50, 0, 150);
        run_phase(0, 50, 150);
        go_idle();

        if (mismatches == 0) begin
            $display("quaternion_slerp test passed");
        end else begin
            $display("quaternion_slerp test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/qs_pkg.sv
src/qs_if.sv
src/quaternion_slerp.sv
src/qs_checker.sv
bench/qs_slerp_checker.sv
bench/tb_quaternion_slerp.sv
